/* rtl/escape_time_fractal_iterator_macros.svh */
// Assertion helpers, clocked on the rising edge, off while reset is low.
`ifndef ESCAPE_TIME_FRACTAL_ITERATOR_MACROS_SVH
`define ESCAPE_TIME_FRACTAL_ITERATOR_MACROS_SVH

// same-cycle implication
`define ETFI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ETFI_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/etfi_pkg.sv */
package etfi_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 28;
    localparam int ITER_BITS = 16;
    localparam int PIX_BITS  = 16;

    localparam int SPAN_BITS = WORD_BITS - 1;
    localparam int MODE_BITS = 2;
    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int EXT_BITS  = 2 * WORD_BITS + 2;
    localparam int MAP_BITS  = PIX_BITS + SPAN_BITS;

    // register file
    localparam int REG_COUNT = 8;
    localparam int DATA_BITS = 32;
    localparam int IDX_BITS  = $clog2(REG_COUNT);
    localparam int ADDR_BITS = IDX_BITS + 2;

    localparam logic [IDX_BITS-1:0] REG_MODE      = IDX_BITS'(0);
    localparam logic [IDX_BITS-1:0] REG_SPAN_RE   = IDX_BITS'(1);
    localparam logic [IDX_BITS-1:0] REG_SPAN_IM   = IDX_BITS'(2);
    localparam logic [IDX_BITS-1:0] REG_CENTRE_RE = IDX_BITS'(3);
    localparam logic [IDX_BITS-1:0] REG_CENTRE_IM = IDX_BITS'(4);
    localparam logic [IDX_BITS-1:0] REG_SEED_RE   = IDX_BITS'(5);
    localparam logic [IDX_BITS-1:0] REG_SEED_IM   = IDX_BITS'(6);
    localparam logic [IDX_BITS-1:0] REG_LIMIT     = IDX_BITS'(7);

    localparam logic [MODE_BITS-1:0] MODE_MANDEL  = MODE_BITS'(0);
    localparam logic [MODE_BITS-1:0] MODE_TRICORN = MODE_BITS'(1);
    localparam logic [MODE_BITS-1:0] MODE_JULIA   = MODE_BITS'(2);

    localparam logic [SPAN_BITS-1:0] SPAN_RESET  = SPAN_BITS'(1) << FRAC_BITS;
    localparam logic [ITER_BITS-1:0] LIMIT_RESET = ITER_BITS'(100);

    // |z|^2 bound of 4.0 at 2*FRAC_BITS fraction bits
    localparam logic [PROD_BITS-1:0] ESC_THR = PROD_BITS'(1) << (2 * FRAC_BITS + 2);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    // back end states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    typedef struct packed {
        logic [MODE_BITS-1:0]        mode;
        logic [SPAN_BITS-1:0]        span_re;
        logic [SPAN_BITS-1:0]        span_im;
        logic signed [WORD_BITS-1:0] centre_re;
        logic signed [WORD_BITS-1:0] centre_im;
        logic signed [WORD_BITS-1:0] seed_re;
        logic signed [WORD_BITS-1:0] seed_im;
        logic [ITER_BITS-1:0]        limit;
    } t_cfg;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] re;
        logic signed [WORD_BITS-1:0] im;
    } t_point;

    typedef struct packed {
        logic a_vld;
        logic b_vld;
    } t_front_sts;

    typedef struct packed {
        logic [1:0] state;
    } t_back_sts;

    // clamp to the signed word range
    function automatic logic signed [WORD_BITS-1:0] sat_word(
        input logic signed [EXT_BITS-1:0] v
    );
        logic all_one;
        logic all_zero;
        all_one  = &v[EXT_BITS-1:WORD_BITS-1];
        all_zero = ~|v[EXT_BITS-1:WORD_BITS-1];
        if (all_one || all_zero) begin
            return v[WORD_BITS-1:0];
        end else if (v[EXT_BITS-1]) begin
            return {1'b1, {(WORD_BITS-1){1'b0}}};
        end else begin
            return {1'b0, {(WORD_BITS-1){1'b1}}};
        end
    endfunction

endpackage

/* rtl/etfi_regs.sv */
module etfi_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [etfi_pkg::ADDR_BITS-1:0] paddr,
    input  logic [etfi_pkg::DATA_BITS-1:0] pwdata,
    output logic [etfi_pkg::DATA_BITS-1:0] prdata,
    output logic                           pready,
    output etfi_pkg::t_cfg                 o_cfg
);
    import etfi_pkg::*;

    t_cfg                r_cfg;
    logic [IDX_BITS-1:0] idx;
    logic                wr_en;

    assign idx    = paddr[ADDR_BITS-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode      <= MODE_MANDEL;
            r_cfg.span_re   <= SPAN_RESET;
            r_cfg.span_im   <= SPAN_RESET;
            r_cfg.centre_re <= '0;
            r_cfg.centre_im <= '0;
            r_cfg.seed_re   <= '0;
            r_cfg.seed_im   <= '0;
            r_cfg.limit     <= LIMIT_RESET;
        end else if (wr_en) begin
            unique case (idx)
                REG_MODE:      r_cfg.mode      <= pwdata[MODE_BITS-1:0];
                REG_SPAN_RE:   r_cfg.span_re   <= pwdata[SPAN_BITS-1:0];
                REG_SPAN_IM:   r_cfg.span_im   <= pwdata[SPAN_BITS-1:0];
                REG_CENTRE_RE: r_cfg.centre_re <= pwdata[WORD_BITS-1:0];
                REG_CENTRE_IM: r_cfg.centre_im <= pwdata[WORD_BITS-1:0];
                REG_SEED_RE:   r_cfg.seed_re   <= pwdata[WORD_BITS-1:0];
                REG_SEED_IM:   r_cfg.seed_im   <= pwdata[WORD_BITS-1:0];
                REG_LIMIT:     r_cfg.limit     <= pwdata[ITER_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_MODE:      prdata = DATA_BITS'(r_cfg.mode);
            REG_SPAN_RE:   prdata = DATA_BITS'(r_cfg.span_re);
            REG_SPAN_IM:   prdata = DATA_BITS'(r_cfg.span_im);
            REG_CENTRE_RE: prdata = DATA_BITS'(unsigned'(r_cfg.centre_re));
            REG_CENTRE_IM: prdata = DATA_BITS'(unsigned'(r_cfg.centre_im));
            REG_SEED_RE:   prdata = DATA_BITS'(unsigned'(r_cfg.seed_re));
            REG_SEED_IM:   prdata = DATA_BITS'(unsigned'(r_cfg.seed_im));
            REG_LIMIT:     prdata = DATA_BITS'(r_cfg.limit);
            default:       prdata = '0;
        endcase
    end

endmodule

/* rtl/etfi_front.sv */
module etfi_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  etfi_pkg::t_cfg                i_cfg,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [etfi_pkg::PIX_BITS-1:0] i_frac_x,
    input  logic [etfi_pkg::PIX_BITS-1:0] i_frac_y,
    output logic                          o_push_valid,
    output etfi_pkg::t_point              o_push_data,
    input  logic                          i_push_ready,
    output etfi_pkg::t_front_sts          o_sts
);
    import etfi_pkg::*;

    // stage A: captured fractions, stage B: span products
    logic                r_a_vld;
    logic                r_b_vld;
    logic [PIX_BITS-1:0] r_fx;
    logic [PIX_BITS-1:0] r_fy;
    logic [MAP_BITS-1:0] r_px;
    logic [MAP_BITS-1:0] r_py;
    logic                b_free;
    logic                a_move;
    logic                acc;

    // centre + floor(frac*span/2^16) - floor(span/2), then clamp
    function automatic logic signed [WORD_BITS-1:0] map_axis(
        input logic [MAP_BITS-1:0]        prod,
        input logic [SPAN_BITS-1:0]       span,
        input logic signed [WORD_BITS-1:0] centre
    );
        logic signed [EXT_BITS-1:0] t;
        t = signed'(EXT_BITS'(prod[MAP_BITS-1:PIX_BITS])) + EXT_BITS'(centre)
            - signed'(EXT_BITS'(span[SPAN_BITS-1:1]));
        return sat_word(t);
    endfunction

    assign b_free  = !r_b_vld || i_push_ready;
    assign a_move  = r_a_vld && b_free;
    assign o_ready = !r_a_vld || b_free;
    assign acc     = i_valid && o_ready;

    assign o_push_valid   = r_b_vld;
    assign o_push_data.re = map_axis(r_px, i_cfg.span_re, i_cfg.centre_re);
    assign o_push_data.im = map_axis(r_py, i_cfg.span_im, i_cfg.centre_im);

    assign o_sts.a_vld = r_a_vld;
    assign o_sts.b_vld = r_b_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            if (acc) begin
                r_a_vld <= 1'b1;
            end else if (a_move) begin
                r_a_vld <= 1'b0;
            end
            if (a_move) begin
                r_b_vld <= 1'b1;
            end else if (i_push_ready) begin
                r_b_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_fx <= i_frac_x;
            r_fy <= i_frac_y;
        end
        if (a_move) begin
            r_px <= MAP_BITS'(r_fx) * MAP_BITS'(i_cfg.span_re);
            r_py <= MAP_BITS'(r_fy) * MAP_BITS'(i_cfg.span_im);
        end
    end

endmodule

/* rtl/etfi_queue.sv */
module etfi_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    input  etfi_pkg::t_point i_push_data,
    output logic             o_push_ready,
    output logic             o_pop_valid,
    output etfi_pkg::t_point o_pop_data,
    input  logic             i_pop_ready
);
    import etfi_pkg::*;

    t_point               r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wp;
    logic [QPTR_BITS-1:0] r_rp;
    logic [QPTR_BITS:0]   r_cnt;
    logic                 push;
    logic                 pop;

    function automatic logic [QPTR_BITS-1:0] wrap_inc(input logic [QPTR_BITS-1:0] p);
        if (p == QPTR_BITS'(QUEUE_DEPTH - 1)) begin
            return '0;
        end else begin
            return p + QPTR_BITS'(1);
        end
    endfunction

    assign o_push_ready = r_cnt != (QPTR_BITS + 1)'(QUEUE_DEPTH);
    assign o_pop_valid  = r_cnt != '0;
    assign o_pop_data   = r_mem[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= wrap_inc(r_wp);
            end
            if (pop) begin
                r_rp <= wrap_inc(r_rp);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + (QPTR_BITS + 1)'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - (QPTR_BITS + 1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

endmodule

/* rtl/etfi_back.sv */
module etfi_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  etfi_pkg::t_cfg                 i_cfg,
    input  logic                           i_pop_valid,
    input  etfi_pkg::t_point               i_pop_data,
    output logic                           o_pop_ready,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [etfi_pkg::ITER_BITS-1:0] o_iter_count,
    output logic                           o_escaped,
    output etfi_pkg::t_back_sts            o_sts
);
    import etfi_pkg::*;

    logic [1:0]                  r_state;
    logic [1:0]                  n_state;
    logic signed [WORD_BITS-1:0] r_zr;
    logic signed [WORD_BITS-1:0] r_zi;
    logic signed [WORD_BITS-1:0] r_cr;
    logic signed [WORD_BITS-1:0] r_ci;
    logic [ITER_BITS-1:0]        r_iter;
    logic                        r_esc;
    logic signed [PROD_BITS-1:0] r_rr;
    logic signed [PROD_BITS-1:0] r_ii;
    logic signed [PROD_BITS-1:0] r_ri;
    logic                        r_out_vld;
    logic [ITER_BITS-1:0]        r_out_iter;
    logic                        r_out_esc;

    logic                        out_free;
    logic                        at_limit;
    logic                        outside;
    logic [PROD_BITS-1:0]        sq;
    logic signed [PROD_BITS-1:0] diff;
    logic signed [EXT_BITS-1:0]  re_ext;
    logic signed [EXT_BITS-1:0]  im_sh;
    logic signed [EXT_BITS-1:0]  im_ext;
    logic signed [WORD_BITS-1:0] n_zr;
    logic signed [WORD_BITS-1:0] n_zi;

    assign out_free = !r_out_vld || i_ready;
    assign at_limit = r_iter >= i_cfg.limit;

    // both squares are non-negative, so the sum fits unsigned
    assign sq      = unsigned'(r_rr) + unsigned'(r_ii);
    assign outside = sq > ESC_THR;
    assign diff    = r_rr - r_ii;
    assign re_ext  = EXT_BITS'(diff >>> FRAC_BITS) + EXT_BITS'(r_cr);
    assign im_sh   = EXT_BITS'(r_ri >>> (FRAC_BITS - 1));

    always_comb begin
        if (i_cfg.mode == MODE_TRICORN) begin
            im_ext = -im_sh + EXT_BITS'(r_ci);
        end else begin
            im_ext = im_sh + EXT_BITS'(r_ci);
        end
    end

    assign n_zr = sat_word(re_ext);
    assign n_zi = sat_word(im_ext);

    assign o_pop_ready  = r_state == S_IDLE;
    assign o_valid      = r_out_vld;
    assign o_iter_count = r_out_iter;
    assign o_escaped    = r_out_esc;
    assign o_sts.state  = r_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_pop_valid) n_state = S_MUL;
            end
            S_MUL: begin
                n_state = at_limit ? S_OUT : S_UPD;
            end
            S_UPD: begin
                n_state = outside ? S_OUT : S_MUL;
            end
            S_OUT: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && out_free) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_pop_valid) begin
                    r_iter <= '0;
                    if (i_cfg.mode == MODE_JULIA) begin
                        r_zr <= i_pop_data.re;
                        r_zi <= i_pop_data.im;
                        r_cr <= i_cfg.seed_re;
                        r_ci <= i_cfg.seed_im;
                    end else begin
                        r_zr <= i_cfg.seed_re;
                        r_zi <= i_cfg.seed_im;
                        r_cr <= i_pop_data.re;
                        r_ci <= i_pop_data.im;
                    end
                end
            end
            S_MUL: begin
                r_esc <= 1'b0;
                r_rr  <= r_zr * r_zr;
                r_ii  <= r_zi * r_zi;
                r_ri  <= r_zr * r_zi;
            end
            S_UPD: begin
                if (outside) begin
                    r_esc <= 1'b1;
                end else begin
                    r_zr   <= n_zr;
                    r_zi   <= n_zi;
                    r_iter <= r_iter + ITER_BITS'(1);
                end
            end
            S_OUT: begin
                if (out_free) begin
                    r_out_iter <= r_iter;
                    r_out_esc  <= r_esc;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

/* rtl/escape_time_fractal_iterator.sv */
// Escape-time fractal iterator: Mandelbrot, tricorn or Julia per pixel.
// Input channel (i_valid/o_ready): one beat is a pixel position, i_frac_x and
//   i_frac_y as unsigned Q0.16 fractions of the view.
// Output channel (o_valid/i_ready): one beat per pixel, o_iter_count and
//   o_escaped, in input order.
// Configuration over the APB port (word registers at 4*index); users write
//   it only while no pixel is in flight, not enforced. pready is tied high.
// Front end maps the pixel to a Q4.28 point; a two-entry queue decouples it
//   from the back end, which runs z = z^2 + c with one shared set of three
//   32x32 multipliers; each iteration is a multiply step, then a bound test
//   and update step.
// The back end takes a new pixel from the queue only once it is idle again,
//   after the last result has gone into the result register.
// Reset (synchronous, active low) empties front, queue and result register
//   and loads the register defaults (Mandelbrot, span 1.0, limit 100).
// A stalled receiver holds the result register; the back end then waits with
//   its finished pixel while the front and queue keep taking beats until full.
`include "escape_time_fractal_iterator_macros.svh"

module escape_time_fractal_iterator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [etfi_pkg::PIX_BITS-1:0]  i_frac_x,
    input  logic [etfi_pkg::PIX_BITS-1:0]  i_frac_y,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [etfi_pkg::ITER_BITS-1:0] o_iter_count,
    output logic                           o_escaped,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [etfi_pkg::ADDR_BITS-1:0] paddr,
    input  logic [etfi_pkg::DATA_BITS-1:0] pwdata,
    output logic [etfi_pkg::DATA_BITS-1:0] prdata,
    output logic                           pready
);
    import etfi_pkg::*;

    t_cfg       cfg;
    t_point     push_data;
    t_point     pop_data;
    logic       push_valid;
    logic       push_ready;
    logic       pop_valid;
    logic       pop_ready;
    t_front_sts front_sts;
    t_back_sts  back_sts;

    // register file
    etfi_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // pixel to complex point
    etfi_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_frac_x     (i_frac_x),
        .i_frac_y     (i_frac_y),
        .o_push_valid (push_valid),
        .o_push_data  (push_data),
        .i_push_ready (push_ready),
        .o_sts        (front_sts)
    );

    // mapped points awaiting the iterator
    etfi_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_data  (push_data),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_data   (pop_data),
        .i_pop_ready  (pop_ready)
    );

    // iteration loop and result register
    etfi_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_pop_valid  (pop_valid),
        .i_pop_data   (pop_data),
        .o_pop_ready  (pop_ready),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_iter_count (o_iter_count),
        .o_escaped    (o_escaped),
        .o_sts        (back_sts)
    );

    // an accepted beat is held in the front's first stage next cycle
    `ETFI_ASSERT_NXT(a_in_captured, i_clk, i_rst_n, i_valid && o_ready,
                     front_sts.a_vld, "input beat lost by front end")

    // a fresh result only ever comes from the back end's output state
    `ETFI_ASSERT_IMP(a_out_source, i_clk, i_rst_n, $rose(o_valid),
                     $past(back_sts.state) == S_OUT, "result raised outside output state")

    // an update either loops back to multiply or finishes the pixel
    `ETFI_ASSERT_NXT(a_upd_next, i_clk, i_rst_n, back_sts.state == S_UPD,
                     back_sts.state == S_MUL || back_sts.state == S_OUT,
                     "bad step after update")

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    import etfi_pkg::*;

    // Mode code 3 has no name in the package; the block treats it as Mandelbrot.
    localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;

    // Quiet cycles allowed before the run is called hung. The slowest legal
    // pixel is a 65535-iteration one.
    localparam int unsigned WATCHDOG_CYCLES = 600000;
    localparam int unsigned REPORT_CAP      = 200;

    // Wide signed accumulator: the sum of two squares can overflow signed 64 bits.
    typedef logic signed [127:0] t_acc;

    localparam t_acc WORD_MAX     = t_acc'(32'sh7FFF_FFFF);
    localparam t_acc WORD_MIN     = t_acc'(32'sh8000_0000);
    // |z|^2 bound of 4.0 with 2*FRAC_BITS fraction bits
    localparam t_acc ESCAPE_BOUND = t_acc'(1) <<< (2 * FRAC_BITS + 2);

    typedef struct {
        logic [PIX_BITS-1:0]  fx;
        logic [PIX_BITS-1:0]  fy;
        logic [ITER_BITS-1:0] count;
        logic                 escaped;
    } t_pixel_verdict;

    // Predicts the escape count of each accepted pixel and checks the results
    // in order against it.
    class escape_tracker;
        t_pixel_verdict pending_verdicts[$];
        int unsigned    mismatches;

        function new();
            mismatches = 0;
        endfunction

        function int unsigned outstanding();
            return pending_verdicts.size();
        endfunction

        function logic signed [WORD_BITS-1:0] clamp_word(t_acc v);
            if (v > WORD_MAX) return 32'sh7FFF_FFFF;
            if (v < WORD_MIN) return 32'sh8000_0000;
            return v[WORD_BITS-1:0];
        endfunction

        // centre + floor(frac * span / 2^16) - floor(span / 2), clamped
        function logic signed [WORD_BITS-1:0] map_axis(logic [PIX_BITS-1:0] frac,
                                                        logic [SPAN_BITS-1:0] span,
                                                        logic signed [WORD_BITS-1:0] centre);
            t_acc p;
            p = (t_acc'(frac) * t_acc'(span)) >>> PIX_BITS;
            p = p + t_acc'(centre) - t_acc'(span >> 1);
            return clamp_word(p);
        endfunction

        function t_pixel_verdict escape_time_of(t_cfg cfg, logic [PIX_BITS-1:0] fx,
                                                logic [PIX_BITS-1:0] fy);
            t_pixel_verdict res;
            logic signed [WORD_BITS-1:0] pr, pi, zr, zi, cr, ci;
            t_acc        rr, ii, nr, ni;
            int unsigned steps;
            pr = map_axis(fx, cfg.span_re, cfg.centre_re);
            pi = map_axis(fy, cfg.span_im, cfg.centre_im);
            if (cfg.mode == MODE_JULIA) begin
                zr = pr;
                zi = pi;
                cr = cfg.seed_re;
                ci = cfg.seed_im;
            end else begin
                zr = cfg.seed_re;
                zi = cfg.seed_im;
                cr = pr;
                ci = pi;
            end
            res.fx      = fx;
            res.fy      = fy;
            res.escaped = 1'b0;
            steps       = 0;
            while (steps < cfg.limit) begin
                rr = t_acc'(zr) * t_acc'(zr);
                ii = t_acc'(zi) * t_acc'(zi);
                if (rr + ii > ESCAPE_BOUND) begin
                    res.escaped = 1'b1;
                    break;
                end
                nr = ((rr - ii) >>> FRAC_BITS) + t_acc'(cr);
                ni = (t_acc'(zr) * t_acc'(zi)) >>> (FRAC_BITS - 1);
                if (cfg.mode == MODE_TRICORN) ni = -ni;   // floor first, then negate
                ni = ni + t_acc'(ci);
                zr = clamp_word(nr);
                zi = clamp_word(ni);
                steps++;
            end
            res.count = ITER_BITS'(steps);
            return res;
        endfunction

        function void note_pixel(t_cfg cfg, logic [PIX_BITS-1:0] fx,
                                 logic [PIX_BITS-1:0] fy);
            pending_verdicts.push_back(escape_time_of(cfg, fx, fy));
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= REPORT_CAP) $display("ERROR %0t: %s", $time, msg);
        endtask

        task check_result(logic [ITER_BITS-1:0] count, logic esc);
            t_pixel_verdict want;
            if (pending_verdicts.size() == 0) begin
                report($sformatf("result beat count=%0d escaped=%0b with no pixel in flight",
                                 count, esc));
                return;
            end
            want = pending_verdicts.pop_front();
            if (count !== want.count)
                report($sformatf("pixel (%h,%h): iter_count %0d, want %0d",
                                 want.fx, want.fy, count, want.count));
            if (esc !== want.escaped)
                report($sformatf("pixel (%h,%h): escaped %b, want %b",
                                 want.fx, want.fy, esc, want.escaped));
        endtask
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    logic [PIX_BITS-1:0]  i_frac_x;
    logic [PIX_BITS-1:0]  i_frac_y;
    logic                 o_valid;
    logic                 i_ready;
    logic [ITER_BITS-1:0] o_iter_count;
    logic                 o_escaped;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [DATA_BITS-1:0] pwdata;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    escape_tracker tracker = new();

    // Shadow of the register file, updated as each APB write lands.
    t_cfg        view_cfg;
    bit          tight_feed;     // no gaps between input beats in this phase
    int unsigned quiet_cycles;

    escape_time_fractal_iterator u_top (.*);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Random idle lengths: mostly none or short, now and then long.
    // ------------------------------------------------------------------
    function automatic int unsigned pick_idle();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 20);
        return $urandom_range(40, 150);
    endfunction

    // Edges of the view are hit more often than a flat draw would.
    function automatic logic [PIX_BITS-1:0] pick_frac();
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return PIX_BITS'($urandom());
    endfunction

    function automatic logic [SPAN_BITS-1:0] random_span();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 6) return SPAN_BITS'($urandom_range(32'h0040_0000, 32'h4000_0000));
        if (r < 8) return SPAN_BITS'($urandom_range(0, 32'h0010_0000));   // zoomed in
        if (r == 8) return SPAN_BITS'($urandom());
        return $urandom_range(0, 1) ? '1 : '0;
    endfunction

    // Q4.28 coordinate: mostly within +/-2, some near the origin, some anywhere.
    function automatic logic [WORD_BITS-1:0] random_coord();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 7) return $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
        if (r < 9) return $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
        return $urandom();
    endfunction

    function automatic t_cfg make_view(logic [MODE_BITS-1:0] mode,
                                       logic [SPAN_BITS-1:0] span_re,
                                       logic [SPAN_BITS-1:0] span_im,
                                       logic [WORD_BITS-1:0] centre_re,
                                       logic [WORD_BITS-1:0] centre_im,
                                       logic [WORD_BITS-1:0] seed_re,
                                       logic [WORD_BITS-1:0] seed_im,
                                       logic [ITER_BITS-1:0] limit);
        t_cfg c;
        c.mode      = mode;
        c.span_re   = span_re;
        c.span_im   = span_im;
        c.centre_re = centre_re;
        c.centre_im = centre_im;
        c.seed_re   = seed_re;
        c.seed_im   = seed_im;
        c.limit     = limit;
        return c;
    endfunction

    function automatic t_cfg random_view();
        t_cfg        c;
        int unsigned r;
        c.mode      = MODE_BITS'($urandom_range(0, 3));
        c.span_re   = random_span();
        c.span_im   = random_span();
        c.centre_re = random_coord();
        c.centre_im = random_coord();
        c.seed_re   = ($urandom_range(0, 2) == 0) ? '0 : random_coord();
        c.seed_im   = ($urandom_range(0, 2) == 0) ? '0 : random_coord();
        // keep limits modest: interior pixels run every step up to the limit
        r = $urandom_range(0, 9);
        if (r == 0)     c.limit = '0;
        else if (r < 8) c.limit = ITER_BITS'($urandom_range(1, 120));
        else            c.limit = ITER_BITS'($urandom_range(121, 300));
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Drivers. Each task is entered and left just after a falling edge.
    // ------------------------------------------------------------------
    task write_reg(input logic [IDX_BITS-1:0] idx, input logic [DATA_BITS-1:0] data);
        psel    = 1'b1;             // setup cycle
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;             // access cycle
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_MODE:      view_cfg.mode      = data[MODE_BITS-1:0];
            REG_SPAN_RE:   view_cfg.span_re   = data[SPAN_BITS-1:0];
            REG_SPAN_IM:   view_cfg.span_im   = data[SPAN_BITS-1:0];
            REG_CENTRE_RE: view_cfg.centre_re = data;
            REG_CENTRE_IM: view_cfg.centre_im = data;
            REG_SEED_RE:   view_cfg.seed_re   = data;
            REG_SEED_IM:   view_cfg.seed_im   = data;
            REG_LIMIT:     view_cfg.limit     = data[ITER_BITS-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task apply_view(input t_cfg c);
        write_reg(REG_MODE,      DATA_BITS'(c.mode));
        write_reg(REG_SPAN_RE,   DATA_BITS'(c.span_re));
        write_reg(REG_SPAN_IM,   DATA_BITS'(c.span_im));
        write_reg(REG_CENTRE_RE, c.centre_re);
        write_reg(REG_CENTRE_IM, c.centre_im);
        write_reg(REG_SEED_RE,   c.seed_re);
        write_reg(REG_SEED_IM,   c.seed_im);
        write_reg(REG_LIMIT,     DATA_BITS'(c.limit));
    endtask

    // One input beat. Valid stays high across back-to-back beats.
    task send_pixel(input logic [PIX_BITS-1:0] fx, input logic [PIX_BITS-1:0] fy);
        int unsigned gap;
        gap = tight_feed ? 0 : pick_idle();
        if (gap != 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid  = 1'b1;
        i_frac_x = fx;
        i_frac_y = fy;
        do @(posedge i_clk); while (!o_ready);
        tracker.note_pixel(view_cfg, fx, fy);
        @(negedge i_clk);
    endtask

    // Drop valid and wait for every pixel in flight to come back, then keep
    // waiting so the back end is surely idle before any register write.
    task settle();
        i_valid = 1'b0;
        while (tracker.outstanding() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task random_phase(input int unsigned n_pixels);
        tight_feed = ($urandom_range(0, 3) == 0);
        apply_view(random_view());
        repeat (n_pixels) send_pixel(pick_frac(), pick_frac());
        settle();
    endtask

    // ------------------------------------------------------------------
    // Result side: random back-pressure, with long always-ready stretches.
    // ------------------------------------------------------------------
    initial begin
        int unsigned stall;
        i_ready = 1'b0;
        forever begin
            if ($urandom_range(0, 5) == 0) begin
                i_ready = 1'b1;
                repeat ($urandom_range(50, 400)) @(negedge i_clk);
            end else begin
                stall = pick_idle();
                if (stall != 0) begin
                    i_ready = 1'b0;
                    repeat (stall) @(negedge i_clk);
                end
                i_ready = 1'b1;
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            tracker.check_result(o_iter_count, o_escaped);
    end

    // Hang detector: counts cycles with no beat on any port.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("FAIL escape_time_fractal_iterator");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_frac_x   = '0;
        i_frac_y   = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        tight_feed = 1'b0;
        view_cfg   = make_view(MODE_MANDEL, SPAN_RESET, SPAN_RESET, '0, '0, '0, '0,
                               LIMIT_RESET);
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Register defaults straight out of reset: view [-0.5, 0.5]^2, limit
        // 100. Corners and the exact centre, which never escapes.
        send_pixel(16'h0000, 16'h0000);
        send_pixel(16'hFFFF, 16'hFFFF);
        send_pixel(16'h0000, 16'hFFFF);
        send_pixel(16'hFFFF, 16'h0000);
        send_pixel(16'h8000, 16'h8000);
        settle();

        // Zero limit: no step at all, even from a point far outside.
        apply_view(make_view(MODE_JULIA, 31'h4000_0000, 31'h4000_0000, '0, '0,
                             32'h7FFF_FFFF, 32'h8000_0000, '0));
        send_pixel(16'h1234, 16'h4321);
        send_pixel(16'hFFFF, 16'h0000);
        settle();

        // Tricorn over [-2, 2]^2
        apply_view(make_view(MODE_TRICORN, 31'h4000_0000, 31'h4000_0000, '0, '0, '0, '0,
                             16'd50));
        send_pixel(16'h0000, 16'h0000);
        send_pixel(16'h8000, 16'h8000);
        send_pixel(16'hA000, 16'h6000);
        settle();

        // Mode code 3 must behave as Mandelbrot; centre at -0.5
        apply_view(make_view(MODE_UNUSED, 31'h3000_0000, 31'h3000_0000, 32'hF800_0000, '0,
                             '0, '0, 16'd30));
        send_pixel(16'h4000, 16'h8000);
        send_pixel(16'hC000, 16'h9000);
        settle();

        // Julia with a classic seed near -0.8 + 0.156i
        apply_view(make_view(MODE_JULIA, 31'h3000_0000, 31'h3000_0000, '0, '0,
                             32'hF333_3333, 32'h027E_F9DB, 16'd64));
        send_pixel(16'h8000, 16'h8000);
        send_pixel(16'h2000, 16'hE000);
        send_pixel(16'hFFFF, 16'h8000);
        settle();

        // Widest span with the centre at both ends: mapped points clamp
        apply_view(make_view(MODE_MANDEL, '1, '1, 32'h7FFF_FFFF, 32'h8000_0000, '0, '0,
                             16'd10));
        send_pixel(16'hFFFF, 16'hFFFF);
        send_pixel(16'h0000, 16'h0000);
        send_pixel(16'hFFFF, 16'h0000);
        settle();

        // Zero span pins every pixel to z = 2 + 0i: |z|^2 sits exactly on the
        // bound, and adding the largest c overflows upwards.
        apply_view(make_view(MODE_JULIA, '0, '0, 32'h2000_0000, '0,
                             32'h7FFF_FFFF, 32'h7FFF_FFFF, '1));
        send_pixel(16'h0000, 16'h0000);
        send_pixel(16'hFFFF, 16'hFFFF);
        settle();

        // z0 = -2i, c = -8: the real part overflows downwards
        apply_view(make_view(MODE_MANDEL, '0, '0, 32'h8000_0000, '0, '0, 32'hE000_0000,
                             16'd20));
        send_pixel(16'h1111, 16'h2222);
        settle();

        // Full limit: c = 0 runs all 65535 steps, c just below 2 escapes after two steps
        apply_view(make_view(MODE_MANDEL, 31'h4000_0000, 31'h4000_0000, '0, '0, '0, '0,
                             '1));
        tight_feed = 1'b1;
        send_pixel(16'h8000, 16'h8000);
        send_pixel(16'hFFFF, 16'h8000);
        settle();

        repeat (10) random_phase(123);

        // settle() has already waited for every pixel to return; the tail
        // catches any stray beat after the last one.
        repeat (20) @(negedge i_clk);
        if (tracker.mismatches == 0) begin
            $display("PASS escape_time_fractal_iterator");
        end else begin
            $display("FAIL escape_time_fractal_iterator");
        end
        $finish;
    end

endmodule
